[design/psqs_pkg.sv]
// ----------------------------------------------------------------------------
// psqs_pkg
// Shared types, codes and the ordering function of the policy queue sorter.
// ----------------------------------------------------------------------------
package psqs_pkg;

   // Default number of stored job entries.
   localparam int QUEUE_DEPTH_DEFAULT = 16;

   // Command queue between the front and the back.
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = 2;
   localparam int CMDQ_CNT_W = 3;

   // Field widths.
   localparam int ID_W   = 8;
   localparam int PRIO_W = 8;
   localparam int SVC_W  = 16;
   localparam int DL_W   = 16;
   localparam int MODE_W = 3;
   localparam int SLOT_W = 4;

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_SORT  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   // Policy modes; codes above real time are invalid.
   typedef enum logic [MODE_W-1:0] {
      POL_FCFS = 3'd0,
      POL_RR   = 3'd1,
      POL_PRIO = 3'd2,
      POL_SJF  = 3'd3,
      POL_RT   = 3'd4
   } policy_type;

   // Sorter states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK
   } back_state_type;

   // One stored job entry (49 bits).
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [SVC_W-1:0]  svc;
      logic              urg;
      logic [DL_W-1:0]   dl;
   } entry_type;

   // One command handed from the front to the back.
   typedef struct packed {
      kind_type  kind;
      entry_type entry;
   } cmd_type;

   // True if entry a must be placed strictly before entry b under mode.
   function automatic logic goes_before(entry_type a, entry_type b,
                                        logic [MODE_W-1:0] mode);
      logic res;
      case (mode)
         POL_FCFS: res = (a.id < b.id);
         POL_PRIO: res = (a.prio < b.prio);
         POL_SJF:  res = (a.svc < b.svc);
         POL_RT: begin
            if (a.urg != b.urg) res = a.urg;
            else                res = (a.dl < b.dl);
         end
         default:  res = 1'b0;
      endcase
      return res;
   endfunction

endpackage

[design/policy_selectable_queue_sorter_top.sv]
// ----------------------------------------------------------------------------
// policy_selectable_queue_sorter_top
// Job queue that reorders its stored entries by a selectable policy on a sort
// request and emits them in the new order.
// ----------------------------------------------------------------------------
// The front queues up to four requests, so loads stream in at one per cycle while the
// back is idle; during a sort the back takes no command and the front queue holds.
// A sort produces each result by one scan of the entry memory's single read port over
// the stored entries, followed by a pick.
// Reset clears the entry count, the drop flag, the policy mode and all queues;
// the entry memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module policy_selectable_queue_sorter_top #(
   parameter int QUEUE_DEPTH = psqs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [1:0]                        req_kind,
   input  logic [psqs_pkg::ID_W-1:0]         req_entry_id,
   input  logic [psqs_pkg::PRIO_W-1:0]       req_priority_level,
   input  logic [psqs_pkg::SVC_W-1:0]        req_service_time,
   input  logic                              req_is_urgent,
   input  logic [psqs_pkg::DL_W-1:0]         req_deadline,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [psqs_pkg::ID_W-1:0]         rsp_out_id,
   output logic [psqs_pkg::PRIO_W-1:0]       rsp_out_priority,
   output logic [psqs_pkg::SVC_W-1:0]        rsp_out_service_time,
   output logic                              rsp_out_urgent,
   output logic [psqs_pkg::DL_W-1:0]         rsp_out_deadline,
   output logic [psqs_pkg::SLOT_W-1:0]       rsp_slot,
   output logic                              rsp_last,
   output logic                              rsp_mode_error,
   output logic                              rsp_overflowed,
   input  logic                              csr_wr_en,
   input  logic [psqs_pkg::MODE_W-1:0]       csr_wr_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [psqs_pkg::MODE_W-1:0] policy_mode_ff;
   psqs_pkg::entry_type         req_entry;
   psqs_pkg::entry_type         rsp_entry;
   logic                        cmd_valid;
   psqs_pkg::cmd_type           cmd;
   logic                        cmd_pop;
   logic                        mem_wr_en;
   logic [IDX_W:0]              mem_wr_addr;
   psqs_pkg::entry_type         mem_wr_data;
   logic                        mem_rd_en;
   logic [IDX_W:0]              mem_rd_addr;
   psqs_pkg::entry_type         mem_rd_data;

   // Policy mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_mode_ff <= psqs_pkg::POL_FCFS;
      end else if (csr_wr_en) begin
         policy_mode_ff <= csr_wr_data;
      end
   end

   // Pack the request fields into one entry.
   assign req_entry.id   = req_entry_id;
   assign req_entry.prio = req_priority_level;
   assign req_entry.svc  = req_service_time;
   assign req_entry.urg  = req_is_urgent;
   assign req_entry.dl   = req_deadline;

   psqs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_kind  (req_kind),
      .req_entry (req_entry),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // Each bank spans the full index range so that {bank, index} stays in range.
   psqs_store #(
      .DEPTH  (2 ** (IDX_W + 1)),
      .ADDR_W (IDX_W + 1)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   psqs_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .policy_mode    (policy_mode_ff),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_entry      (rsp_entry),
      .rsp_slot       (rsp_slot),
      .rsp_last       (rsp_last),
      .rsp_mode_error (rsp_mode_error),
      .rsp_overflowed (rsp_overflowed)
   );

   // Unpack the result entry.
   assign rsp_out_id           = rsp_entry.id;
   assign rsp_out_priority     = rsp_entry.prio;
   assign rsp_out_service_time = rsp_entry.svc;
   assign rsp_out_urgent       = rsp_entry.urg;
   assign rsp_out_deadline     = rsp_entry.dl;

   // The back only takes a command that the front offers.
   a_pop_needs_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from an empty queue");

   // A full front queue always has a command waiting for the back.
   a_full_has_cmd: assert property (@(posedge clock) disable iff (reset)
      req_full |-> cmd_valid)
      else $error("front reports full with no command pending");

   // Scan reads and stores are never issued in the same cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("entry memory read and write in the same cycle");

   // No result is offered right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result offered right after reset");

endmodule

[design/psqs_front.sv]
// ----------------------------------------------------------------------------
// psqs_front
// Accepts requests, drops unknown kinds and queues commands for the back.
// ----------------------------------------------------------------------------
module psqs_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [1:0]                        req_kind,
   input  psqs_pkg::entry_type               req_entry,
   output logic                              cmd_valid,
   output psqs_pkg::cmd_type                 cmd,
   input  logic                              cmd_pop
);

   psqs_pkg::cmd_type                   queue_ff [psqs_pkg::CMDQ_DEPTH];
   logic [psqs_pkg::CMDQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [psqs_pkg::CMDQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [psqs_pkg::CMDQ_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                                accept;
   logic                                known_kind;
   logic                                do_push;
   logic                                do_pop;

   // Classify the request; kinds without meaning are accepted and dropped.
   assign known_kind = req_kind inside {psqs_pkg::KIND_LOAD, psqs_pkg::KIND_SORT,
                                        psqs_pkg::KIND_CLEAR};
   assign req_full   = (cnt_ff == psqs_pkg::CMDQ_CNT_W'(psqs_pkg::CMDQ_DEPTH));
   assign accept     = req_push && !req_full;
   assign do_push    = accept && known_kind;
   assign do_pop     = cmd_pop && cmd_valid;

   assign cmd_valid  = (cnt_ff != '0);
   assign cmd        = queue_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (!do_push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff].kind  <= psqs_pkg::kind_type'(req_kind);
         queue_ff[wr_ptr_ff].entry <= req_entry;
      end
   end

endmodule

[design/psqs_store.sv]
// ----------------------------------------------------------------------------
// psqs_store
// Entry memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module psqs_store #(
   parameter int DEPTH  = 2 * psqs_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  psqs_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output psqs_pkg::entry_type rd_data
);

   psqs_pkg::entry_type mem [DEPTH];
   psqs_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/psqs_back.sv]
// ----------------------------------------------------------------------------
// psqs_back
// Executes commands: stores loads, clears, and runs a stable selection sort
// that writes the new order into the other memory bank while emitting it.
// ----------------------------------------------------------------------------
module psqs_back #(
   parameter int QUEUE_DEPTH = psqs_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int IDX_W       = $clog2(QUEUE_DEPTH),
   parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [psqs_pkg::MODE_W-1:0]   policy_mode,
   input  logic                          cmd_valid,
   input  psqs_pkg::cmd_type             cmd,
   output logic                          cmd_pop,
   output logic                          mem_wr_en,
   output logic [IDX_W:0]                mem_wr_addr,
   output psqs_pkg::entry_type           mem_wr_data,
   output logic                          mem_rd_en,
   output logic [IDX_W:0]                mem_rd_addr,
   input  psqs_pkg::entry_type           mem_rd_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output psqs_pkg::entry_type           rsp_entry,
   output logic [psqs_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                          rsp_last,
   output logic                          rsp_mode_error,
   output logic                          rsp_overflowed
);

   psqs_pkg::back_state_type            state_ff, state_in;
   logic                                bank_ff, bank_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic                                drop_ff, drop_in;
   logic [psqs_pkg::MODE_W-1:0]         mode_ff, mode_in;
   logic                                err_ff, err_in;
   logic [CNT_W-1:0]                    out_k_ff, out_k_in;
   logic [CNT_W-1:0]                    rd_idx_ff, rd_idx_in;
   logic                                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]                    rd_tag_ff, rd_tag_in;
   logic                                best_vld_ff, best_vld_in;
   psqs_pkg::entry_type                 best_ff, best_in;
   logic [IDX_W-1:0]                    best_tag_ff, best_tag_in;
   logic [QUEUE_DEPTH-1:0]              taken_ff, taken_in;
   logic                                rsp_vld_ff, rsp_vld_in;
   psqs_pkg::entry_type                 rsp_entry_ff, rsp_entry_in;
   logic [psqs_pkg::SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;
   logic                                rsp_last_ff, rsp_last_in;
   logic                                rsp_err_ff, rsp_err_in;
   logic                                rsp_ovf_ff, rsp_ovf_in;
   logic                                emit_ok;
   logic                                is_last;
   logic                                scan_done;
   logic                                is_sort;

   assign emit_ok   = !rsp_vld_ff || rsp_pop;
   assign is_last   = ((out_k_ff + CNT_W'(1)) == count_ff);
   assign scan_done = (rd_idx_ff == count_ff) && !rd_vld_ff;
   assign is_sort   = cmd_valid && (cmd.kind == psqs_pkg::KIND_SORT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psqs_pkg::ST_IDLE: begin
            if (is_sort && (count_ff != '0)) state_in = psqs_pkg::ST_SCAN;
         end
         psqs_pkg::ST_SCAN: begin
            if (scan_done) state_in = psqs_pkg::ST_PICK;
         end
         psqs_pkg::ST_PICK: begin
            if (emit_ok) state_in = is_last ? psqs_pkg::ST_IDLE : psqs_pkg::ST_SCAN;
         end
         default: state_in = psqs_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath next values.
   always_comb begin
      cmd_pop      = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = {bank_ff, count_ff[IDX_W-1:0]};
      mem_wr_data  = cmd.entry;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = {bank_ff, rd_idx_ff[IDX_W-1:0]};
      bank_in      = bank_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      mode_in      = mode_ff;
      err_in       = err_ff;
      out_k_in     = out_k_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = 1'b0;
      rd_tag_in    = rd_tag_ff;
      best_vld_in  = best_vld_ff;
      best_in      = best_ff;
      best_tag_in  = best_tag_ff;
      taken_in     = taken_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_pop;
      rsp_entry_in = rsp_entry_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         psqs_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  psqs_pkg::KIND_LOAD: begin
                     if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  psqs_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     drop_in  = 1'b0;
                  end
                  psqs_pkg::KIND_SORT: begin
                     mode_in     = policy_mode;
                     err_in      = (policy_mode > psqs_pkg::POL_RT);
                     out_k_in    = '0;
                     rd_idx_in   = '0;
                     best_vld_in = 1'b0;
                     taken_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         psqs_pkg::ST_SCAN: begin
            // Issue one read per cycle over the active bank.
            if (rd_idx_ff != count_ff) begin
               mem_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               rd_tag_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            // Keep the first untaken entry that no later one beats.
            if (rd_vld_ff && !taken_ff[rd_tag_ff] &&
                (!best_vld_ff ||
                 psqs_pkg::goes_before(mem_rd_data, best_ff, mode_ff))) begin
               best_vld_in = 1'b1;
               best_in     = mem_rd_data;
               best_tag_in = rd_tag_ff;
            end
         end
         psqs_pkg::ST_PICK: begin
            if (emit_ok) begin
               mem_wr_en    = 1'b1;
               mem_wr_addr  = {!bank_ff, out_k_ff[IDX_W-1:0]};
               mem_wr_data  = best_ff;
               taken_in[best_tag_ff] = 1'b1;
               rsp_vld_in   = 1'b1;
               rsp_entry_in = best_ff;
               rsp_slot_in  = psqs_pkg::SLOT_W'(out_k_ff);
               rsp_last_in  = is_last;
               rsp_err_in   = err_ff;
               rsp_ovf_in   = drop_ff;
               out_k_in     = out_k_ff + CNT_W'(1);
               rd_idx_in    = '0;
               best_vld_in  = 1'b0;
               if (is_last) bank_in = !bank_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= psqs_pkg::ST_IDLE;
         bank_ff     <= 1'b0;
         count_ff    <= '0;
         drop_ff     <= 1'b0;
         rd_vld_ff   <= 1'b0;
         best_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         taken_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         bank_ff     <= bank_in;
         count_ff    <= count_in;
         drop_ff     <= drop_in;
         rd_vld_ff   <= rd_vld_in;
         best_vld_ff <= best_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         taken_ff    <= taken_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      err_ff       <= err_in;
      out_k_ff     <= out_k_in;
      rd_idx_ff    <= rd_idx_in;
      rd_tag_ff    <= rd_tag_in;
      best_ff      <= best_in;
      best_tag_ff  <= best_tag_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_empty      = !rsp_vld_ff;
   assign rsp_entry      = rsp_entry_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_mode_error = rsp_err_ff;
   assign rsp_overflowed = rsp_ovf_ff;

endmodule

[bench/psqs_order_check.sv]
// ----------------------------------------------------------------------------
// psqs_order_check
// Watches the request, result and register ports of the policy queue sorter,
// keeps its own copy of the job queue, predicts every emitted entry and
// compares each popped result with the oldest prediction.
// ----------------------------------------------------------------------------
module psqs_order_check #(
   parameter int QUEUE_DEPTH = psqs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  logic                        req_full,
   input  logic [1:0]                  req_kind,
   input  logic [psqs_pkg::ID_W-1:0]   req_entry_id,
   input  logic [psqs_pkg::PRIO_W-1:0] req_priority_level,
   input  logic [psqs_pkg::SVC_W-1:0]  req_service_time,
   input  logic                        req_is_urgent,
   input  logic [psqs_pkg::DL_W-1:0]   req_deadline,
   input  logic                        rsp_empty,
   input  logic                        rsp_pop,
   input  logic [psqs_pkg::ID_W-1:0]   rsp_out_id,
   input  logic [psqs_pkg::PRIO_W-1:0] rsp_out_priority,
   input  logic [psqs_pkg::SVC_W-1:0]  rsp_out_service_time,
   input  logic                        rsp_out_urgent,
   input  logic [psqs_pkg::DL_W-1:0]   rsp_out_deadline,
   input  logic [psqs_pkg::SLOT_W-1:0] rsp_slot,
   input  logic                        rsp_last,
   input  logic                        rsp_mode_error,
   input  logic                        rsp_overflowed,
   input  logic                        csr_wr_en,
   input  logic [psqs_pkg::MODE_W-1:0] csr_wr_data,
   output int                          error_count,
   output int                          pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   // One emitted queue position as it should appear on the result ports.
   typedef struct packed {
      logic [psqs_pkg::ID_W-1:0]   id;
      logic [psqs_pkg::PRIO_W-1:0] prio;
      logic [psqs_pkg::SVC_W-1:0]  svc;
      logic                        urg;
      logic [psqs_pkg::DL_W-1:0]   dl;
      logic [psqs_pkg::SLOT_W-1:0] slot;
      logic                        last;
      logic                        mode_error;
      logic                        overflowed;
   } emitted_entry_type;

   // Local copy of the job queue and the policy register.
   psqs_pkg::entry_type         jobs [QUEUE_DEPTH];
   int unsigned                 job_count;
   logic                        dropped;
   logic [psqs_pkg::MODE_W-1:0] policy;

   // Entries predicted by sort requests, oldest first.
   emitted_entry_type emitted_order [$];
   int                reported;

   // True if job a has to be served strictly ahead of job b.
   function automatic bit ranks_ahead(psqs_pkg::entry_type a, psqs_pkg::entry_type b,
                                      logic [psqs_pkg::MODE_W-1:0] mode);
      case (mode)
         psqs_pkg::POL_FCFS: return a.id < b.id;
         psqs_pkg::POL_PRIO: return a.prio < b.prio;
         psqs_pkg::POL_SJF:  return a.svc < b.svc;
         psqs_pkg::POL_RT: begin
            if (a.urg != b.urg) return a.urg;
            return a.dl < b.dl;
         end
         default:  return 1'b0;
      endcase
   endfunction

   // Stable insertion sort of the stored jobs, written back in place.
   task automatic reorder_jobs();
      psqs_pkg::entry_type cur;
      int                  j;
      for (int i = 1; i < job_count; i++) begin
         cur = jobs[i];
         j   = i;
         while (j > 0 && ranks_ahead(cur, jobs[j-1], policy)) begin
            jobs[j] = jobs[j-1];
            j--;
         end
         jobs[j] = cur;
      end
   endtask

   // Apply one accepted request to the local queue.
   task automatic take_request(logic [1:0] kind, psqs_pkg::entry_type job);
      emitted_entry_type r;
      logic              bad_mode;
      case (kind)
         psqs_pkg::KIND_LOAD: begin
            if (job_count < QUEUE_DEPTH) begin
               jobs[job_count] = job;
               job_count++;
            end else begin
               dropped = 1'b1;
            end
         end
         psqs_pkg::KIND_CLEAR: begin
            job_count = 0;
            dropped   = 1'b0;
         end
         psqs_pkg::KIND_SORT: begin
            bad_mode = (policy > psqs_pkg::POL_RT);
            if (!bad_mode && policy != psqs_pkg::POL_RR) reorder_jobs();
            for (int k = 0; k < job_count; k++) begin
               r.id         = jobs[k].id;
               r.prio       = jobs[k].prio;
               r.svc        = jobs[k].svc;
               r.urg        = jobs[k].urg;
               r.dl         = jobs[k].dl;
               r.slot       = psqs_pkg::SLOT_W'(k);
               r.last       = (k == job_count - 1);
               r.mode_error = bad_mode;
               r.overflowed = dropped;
               emitted_order.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   function automatic string show(emitted_entry_type r);
      return $sformatf({"id=%0d prio=%0d svc=%0d urg=%0b dl=%0d slot=%0d ",
                        "last=%0b err=%0b ovf=%0b"},
                       r.id, r.prio, r.svc, r.urg, r.dl, r.slot, r.last, r.mode_error,
                       r.overflowed);
   endfunction

   // Compare one popped result with the oldest prediction.
   task automatic check_result();
      emitted_entry_type got, want;
      got = '{id: rsp_out_id, prio: rsp_out_priority, svc: rsp_out_service_time,
              urg: rsp_out_urgent, dl: rsp_out_deadline, slot: rsp_slot, last: rsp_last,
              mode_error: rsp_mode_error, overflowed: rsp_overflowed};
      if (emitted_order.size() == 0) begin
         error_count++;
         if (reported < 10) begin
            reported++;
            $display("%0t: result with no request waiting: %s", $realtime, show(got));
         end
      end else begin
         want = emitted_order.pop_front();
         if (got.id !== want.id || got.prio !== want.prio || got.svc !== want.svc ||
             got.urg !== want.urg || got.dl !== want.dl || got.slot !== want.slot ||
             got.last !== want.last || got.mode_error !== want.mode_error ||
             got.overflowed !== want.overflowed) begin
            error_count++;
            if (reported < 10) begin
               reported++;
               $display("%0t: mismatch\n   expected %s\n   actual   %s",
                        $realtime, show(want), show(got));
            end
         end
      end
   endtask

   // Sample all channels at the rising edge, before the block updates them.
   always @(posedge clock) begin
      if (reset) begin
         job_count   = 0;
         dropped     = 1'b0;
         policy      = psqs_pkg::POL_FCFS;
         error_count = 0;
         reported    = 0;
         emitted_order.delete();
      end else begin
         if (csr_wr_en) policy = csr_wr_data;
         if (req_push && !req_full) begin
            take_request(req_kind, '{id: req_entry_id, prio: req_priority_level,
                                     svc: req_service_time, urg: req_is_urgent,
                                     dl: req_deadline});
         end
         if (rsp_pop && !rsp_empty) check_result();
      end
      pending_results = emitted_order.size();
   end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives load, sort and clear requests and policy register writes into the
// policy queue sorter under random idling on both channels, and reports the
// verdict of the order checker.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Request kind the block ignores, and the highest policy code.
   localparam logic [1:0]                  KIND_UNUSED = 2'd3;
   localparam logic [psqs_pkg::MODE_W-1:0] MODE_TOP    = 3'd7;
   localparam int                          DEPTH       = psqs_pkg::QUEUE_DEPTH_DEFAULT;

   logic                          clock;
   logic                          reset;
   logic                          req_push;
   logic                          req_full;
   logic [1:0]                    req_kind;
   logic [psqs_pkg::ID_W-1:0]     req_entry_id;
   logic [psqs_pkg::PRIO_W-1:0]   req_priority_level;
   logic [psqs_pkg::SVC_W-1:0]    req_service_time;
   logic                          req_is_urgent;
   logic [psqs_pkg::DL_W-1:0]     req_deadline;
   logic                          rsp_empty;
   logic                          rsp_pop;
   logic [psqs_pkg::ID_W-1:0]     rsp_out_id;
   logic [psqs_pkg::PRIO_W-1:0]   rsp_out_priority;
   logic [psqs_pkg::SVC_W-1:0]    rsp_out_service_time;
   logic                          rsp_out_urgent;
   logic [psqs_pkg::DL_W-1:0]     rsp_out_deadline;
   logic [psqs_pkg::SLOT_W-1:0]   rsp_slot;
   logic                          rsp_last;
   logic                          rsp_mode_error;
   logic                          rsp_overflowed;
   logic                          csr_wr_en;
   logic [psqs_pkg::MODE_W-1:0]   csr_wr_data;

   int send_idle;
   int recv_idle;
   int requests_sent;
   int error_count;
   int pending_results;

   policy_selectable_queue_sorter_top #(.QUEUE_DEPTH(DEPTH)) DUT (.*);

   psqs_order_check #(.QUEUE_DEPTH(DEPTH)) order_check (.*);

   // Clock with a 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The receiver pops at random, as often as recv_idle allows.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic psqs_pkg::entry_type make_job(logic [psqs_pkg::ID_W-1:0] id,
                                                    logic [psqs_pkg::PRIO_W-1:0] prio,
                                                    logic [psqs_pkg::SVC_W-1:0] svc,
                                                    logic urg,
                                                    logic [psqs_pkg::DL_W-1:0] dl);
      return '{id: id, prio: prio, svc: svc, urg: urg, dl: dl};
   endfunction

   // Field value biased toward the extremes and toward a few small values,
   // so that equal keys show up often.
   function automatic logic [15:0] pick_value(int width);
      logic [15:0] mask;
      mask = 16'((32'd1 << width) - 1);
      case ($urandom_range(5))
         0:       return '0;
         1:       return mask;
         2:       return 16'($urandom_range(3));
         default: return 16'($urandom) & mask;
      endcase
   endfunction

   function automatic psqs_pkg::entry_type random_job();
      return make_job(8'(pick_value(psqs_pkg::ID_W)), 8'(pick_value(psqs_pkg::PRIO_W)),
                      pick_value(psqs_pkg::SVC_W), 1'($urandom_range(1)),
                      pick_value(psqs_pkg::DL_W));
   endfunction

   // Send one request, with random idle cycles ahead of it.
   task automatic send_request(logic [1:0] kind, psqs_pkg::entry_type job);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push           <= 1'b1;
      req_kind           <= kind;
      req_entry_id       <= job.id;
      req_priority_level <= job.prio;
      req_service_time   <= job.svc;
      req_is_urgent      <= job.urg;
      req_deadline       <= job.dl;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (kind != KIND_UNUSED) requests_sent++;
   endtask

   // Stop sending until every predicted entry has been popped, then let the
   // block finish any loads or clears still in its request queue.
   task automatic wait_settled();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (30) @(posedge clock);
   endtask

   // One register write, then the write enable is dropped again.
   task automatic set_policy(logic [psqs_pkg::MODE_W-1:0] mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly a well-formed run: optional clear, a few loads, a sort. Now and
   // then an ignored request, an empty sort or an overfilled queue.
   task automatic run_batch();
      int loads;
      if ($urandom_range(2) == 0) send_request(psqs_pkg::KIND_CLEAR, random_job());
      if ($urandom_range(7) == 0) loads = $urandom_range(10, DEPTH + 2);
      else                        loads = $urandom_range(1, 5);
      repeat (loads) send_request(psqs_pkg::KIND_LOAD, random_job());
      case ($urandom_range(9))
         0:       send_request(KIND_UNUSED, random_job());
         1:       send_request(psqs_pkg::KIND_CLEAR, random_job());
         default: ;
      endcase
      send_request(psqs_pkg::KIND_SORT, random_job());
      if ($urandom_range(4) == 0) send_request(psqs_pkg::KIND_SORT, random_job());
   endtask

   initial begin
      int target;
      reset              = 1'b1;
      req_push           = 1'b0;
      req_kind           = psqs_pkg::KIND_LOAD;
      req_entry_id       = '0;
      req_priority_level = '0;
      req_service_time   = '0;
      req_is_urgent      = 1'b0;
      req_deadline       = '0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = psqs_pkg::POL_FCFS;
      send_idle          = 38;
      recv_idle          = 66;
      requests_sent      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty sort, ignored kind, extreme entries with tied keys,
      // then one sort under every policy code, valid or not.
      send_request(psqs_pkg::KIND_SORT, make_job(8'h00, 8'h00, 16'h0000, 1'b0, 16'h0000));
      send_request(KIND_UNUSED, make_job(8'hFF, 8'hFF, 16'hFFFF, 1'b1, 16'hFFFF));
      send_request(psqs_pkg::KIND_LOAD, make_job(8'hFF, 8'h00, 16'hFFFF, 1'b0, 16'h0000));
      send_request(psqs_pkg::KIND_LOAD, make_job(8'h00, 8'hFF, 16'h0000, 1'b1, 16'hFFFF));
      send_request(psqs_pkg::KIND_LOAD, make_job(8'h80, 8'hFF, 16'h0000, 1'b1, 16'h0000));
      send_request(psqs_pkg::KIND_LOAD, make_job(8'h00, 8'h07, 16'h1234, 1'b0, 16'hFFFF));
      send_request(psqs_pkg::KIND_LOAD, make_job(8'h55, 8'hAA, 16'h5555, 1'b1, 16'hAAAA));
      send_request(psqs_pkg::KIND_SORT, make_job(8'h00, 8'h00, 16'h0000, 1'b0, 16'h0000));
      for (int m = psqs_pkg::POL_RR; m <= MODE_TOP; m++) begin
         wait_settled();
         set_policy(psqs_pkg::MODE_W'(m));
         send_request(psqs_pkg::KIND_SORT, random_job());
      end
      wait_settled();
      send_request(psqs_pkg::KIND_CLEAR, random_job());
      send_request(psqs_pkg::KIND_SORT, random_job());
      wait_settled();

      // Random: three idling profiles, the policy changed while idle.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle = 38; recv_idle = 66; end
            1: begin send_idle = 66; recv_idle = 38; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         target = requests_sent + 78;
         set_policy(phase == 0 ? psqs_pkg::POL_FCFS : MODE_TOP);
         while (requests_sent < target) begin
            repeat ($urandom_range(1, 3)) run_batch();
            wait_settled();
            set_policy(psqs_pkg::MODE_W'($urandom_range(MODE_TOP)));
         end
      end

      wait_settled();
      if (error_count == 0 && pending_results == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
